// ===== design/ddrrf_pkg.sv =====
package ddrrf_pkg;

    localparam int MAX_ROBOTS_DEF = 16;

    localparam int ROBOT_W   = 4;
    localparam int SPEED_W   = 16;
    localparam int COUNT_W   = 5;
    localparam int BYTE_W    = 8;
    localparam int IN_DATA_W = 40;
    localparam int OUT_DATA_W = 16;

    localparam int FRAME_LEN = 7;
    localparam int BIDX_W    = 3;

    localparam logic [BYTE_W-1:0] HDR_START = 8'd128;
    localparam logic [BYTE_W-1:0] HDR_SAFE  = 8'd132;
    localparam logic [BYTE_W-1:0] HDR_DRIVE = 8'd145;

    localparam logic [BIDX_W-1:0] BYTE_START = 3'd0;
    localparam logic [BIDX_W-1:0] BYTE_SAFE  = 3'd1;
    localparam logic [BIDX_W-1:0] BYTE_DRIVE = 3'd2;
    localparam logic [BIDX_W-1:0] BYTE_R_HI  = 3'd3;
    localparam logic [BIDX_W-1:0] BYTE_R_LO  = 3'd4;
    localparam logic [BIDX_W-1:0] BYTE_L_HI  = 3'd5;
    localparam logic [BIDX_W-1:0] BYTE_L_LO  = 3'd6;

    localparam logic signed [SPEED_W+1:0] SPEED_LIMIT = 18'sd499;

    localparam logic MODE_SET  = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SEND
    } state_t;

    typedef struct packed {
        logic set;      // store speeds from the input word
        logic tick;     // latch served robot, start table read, move pointer
        logic shape;    // latch shaped speeds, restart byte index
        logic advance;  // step to next frame byte
    } cmd_t;

    typedef struct packed {
        logic last_byte;
    } status_t;

    // triple (when asked), then clamp to +/-499; returns 16-bit two's complement
    function automatic logic [SPEED_W-1:0] shape_speed(
        input logic signed [SPEED_W-1:0] s,
        input logic                      triple
    );
        logic signed [SPEED_W+1:0] ext;
        logic signed [SPEED_W+1:0] v;
        ext = (SPEED_W+2)'(s);
        v   = triple ? (ext + (ext <<< 1)) : ext;
        if (v > SPEED_LIMIT)
            v = SPEED_LIMIT;
        else if (v < -SPEED_LIMIT)
            v = -SPEED_LIMIT;
        return v[SPEED_W-1:0];
    endfunction

endpackage

// ===== design/ddrrf_ram.sv =====
module ddrrf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem_reg[waddr] <= wdata;
        if (re)
            rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/ddrrf_ctrl.sv =====
module ddrrf_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_mode,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output ddrrf_pkg::cmd_t     cmd,
    input  ddrrf_pkg::status_t  status
);

    ddrrf_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ddrrf_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        cmd         = '0;
        unique case (state_reg)
            ddrrf_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_mode == ddrrf_pkg::MODE_TICK)
                    begin
                        cmd.tick   = 1'b1;
                        state_next = ddrrf_pkg::ST_READ;
                    end
                    else
                        cmd.set = 1'b1;
                end
            end
            ddrrf_pkg::ST_READ:
            begin
                cmd.shape  = 1'b1;
                state_next = ddrrf_pkg::ST_SEND;
            end
            ddrrf_pkg::ST_SEND:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.advance = 1'b1;
                    if (status.last_byte)
                        state_next = ddrrf_pkg::ST_IDLE;
                end
            end
            default:
                state_next = ddrrf_pkg::ST_IDLE;
        endcase
    end

endmodule

// ===== design/ddrrf_dp.sv =====
module ddrrf_dp #(
    parameter int MAX_ROBOTS = ddrrf_pkg::MAX_ROBOTS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [ddrrf_pkg::COUNT_W-1:0]        cfg_wdata,
    input  logic [ddrrf_pkg::IN_DATA_W-1:0]      in_data,
    output logic [ddrrf_pkg::OUT_DATA_W-1:0]     out_data,
    output logic                                 out_last,
    input  ddrrf_pkg::cmd_t                      cmd,
    output ddrrf_pkg::status_t                   status
);

    localparam int IDX_W  = (MAX_ROBOTS > 1) ? $clog2(MAX_ROBOTS) : 1;
    localparam int CNT_W  = $clog2(MAX_ROBOTS + 1);
    localparam int CMP_W  = (CNT_W > ddrrf_pkg::COUNT_W) ? CNT_W : ddrrf_pkg::COUNT_W;
    localparam int RW_W   = IDX_W + ddrrf_pkg::ROBOT_W;
    localparam int TGT_W  = (IDX_W > ddrrf_pkg::ROBOT_W) ? IDX_W : ddrrf_pkg::ROBOT_W;
    localparam int WORD_W = 2 * ddrrf_pkg::SPEED_W;

    logic [ddrrf_pkg::ROBOT_W-1:0] in_robot;
    logic [ddrrf_pkg::SPEED_W-1:0] in_right;
    logic [ddrrf_pkg::SPEED_W-1:0] in_left;

    assign in_robot = in_data[ddrrf_pkg::ROBOT_W-1:0];
    assign in_right = in_data[ddrrf_pkg::ROBOT_W +: ddrrf_pkg::SPEED_W];
    assign in_left  = in_data[ddrrf_pkg::ROBOT_W + ddrrf_pkg::SPEED_W +: ddrrf_pkg::SPEED_W];

    logic [ddrrf_pkg::COUNT_W-1:0] count_reg;
    logic [IDX_W-1:0]              ptr_reg;
    logic [MAX_ROBOTS-1:0]         valid_reg;
    logic                          rd_valid_reg;
    logic [IDX_W-1:0]              who_reg;
    logic [ddrrf_pkg::SPEED_W-1:0] right_reg;
    logic [ddrrf_pkg::SPEED_W-1:0] left_reg;
    logic [ddrrf_pkg::BIDX_W-1:0]  bidx_reg;

    // effective count: 0 acts as 1, above capacity acts as MAX_ROBOTS
    logic [CMP_W-1:0] count_wide;
    logic [CNT_W-1:0] count_eff;

    always_comb
    begin
        count_wide = CMP_W'(count_reg);
        if (count_wide == '0)
            count_eff = CNT_W'(1);
        else if (count_wide > CMP_W'(MAX_ROBOTS))
            count_eff = CNT_W'(MAX_ROBOTS);
        else
            count_eff = count_wide[CNT_W-1:0];
    end

    logic [IDX_W-1:0] who;
    logic [CNT_W-1:0] who_plus;
    logic [IDX_W-1:0] ptr_next;

    assign who      = (CNT_W'(ptr_reg) < count_eff) ? ptr_reg : '0;
    assign who_plus = CNT_W'(who) + CNT_W'(1);
    assign ptr_next = (who_plus == count_eff) ? '0 : who_plus[IDX_W-1:0];

    logic [RW_W-1:0]  robot_wide;
    logic             set_ok;
    logic [IDX_W-1:0] waddr;

    assign robot_wide = RW_W'(in_robot);
    assign set_ok     = robot_wide < RW_W'(MAX_ROBOTS);
    assign waddr      = robot_wide[IDX_W-1:0];

    logic [WORD_W-1:0] rd_word;

    ddrrf_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_ROBOTS)
    ) u_speed_ram (
        .clk   (clk),
        .we    (cmd.set && set_ok),
        .waddr (waddr),
        .wdata ({in_left, in_right}),
        .re    (cmd.tick),
        .raddr (who),
        .rdata (rd_word)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= ddrrf_pkg::COUNT_W'(1);
            ptr_reg   <= '0;
            valid_reg <= '0;
            bidx_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
                count_reg <= cfg_wdata;
            if (cmd.set && set_ok)
                valid_reg[waddr] <= 1'b1;
            if (cmd.tick)
                ptr_reg <= ptr_next;
            if (cmd.shape)
                bidx_reg <= ddrrf_pkg::BYTE_START;
            else if (cmd.advance)
                bidx_reg <= bidx_reg + ddrrf_pkg::BIDX_W'(1);
        end
    end

    // never-written entries read as zero speed
    logic signed [ddrrf_pkg::SPEED_W-1:0] rs;
    logic signed [ddrrf_pkg::SPEED_W-1:0] ls;
    logic                                 triple;

    assign rs     = rd_valid_reg ? rd_word[ddrrf_pkg::SPEED_W-1:0] : '0;
    assign ls     = rd_valid_reg ? rd_word[WORD_W-1:ddrrf_pkg::SPEED_W] : '0;
    assign triple = (rs[ddrrf_pkg::SPEED_W-1] == ls[ddrrf_pkg::SPEED_W-1]);

    always_ff @(posedge clk)
    begin
        if (cmd.tick)
        begin
            who_reg      <= who;
            rd_valid_reg <= valid_reg[who];
        end
        if (cmd.shape)
        begin
            right_reg <= ddrrf_pkg::shape_speed(rs, triple);
            left_reg  <= ddrrf_pkg::shape_speed(ls, triple);
        end
    end

    logic [ddrrf_pkg::BYTE_W-1:0] frame_byte;
    logic [TGT_W-1:0]             who_wide;

    always_comb
    begin
        unique case (bidx_reg)
            ddrrf_pkg::BYTE_START: frame_byte = ddrrf_pkg::HDR_START;
            ddrrf_pkg::BYTE_SAFE:  frame_byte = ddrrf_pkg::HDR_SAFE;
            ddrrf_pkg::BYTE_DRIVE: frame_byte = ddrrf_pkg::HDR_DRIVE;
            ddrrf_pkg::BYTE_R_HI:  frame_byte = right_reg[15:8];
            ddrrf_pkg::BYTE_R_LO:  frame_byte = right_reg[7:0];
            ddrrf_pkg::BYTE_L_HI:  frame_byte = left_reg[15:8];
            ddrrf_pkg::BYTE_L_LO:  frame_byte = left_reg[7:0];
            default:               frame_byte = '0;
        endcase
    end

    assign who_wide         = TGT_W'(who_reg);
    assign out_data         = {4'b0000, who_wide[ddrrf_pkg::ROBOT_W-1:0], frame_byte};
    assign out_last         = (bidx_reg == ddrrf_pkg::BYTE_L_LO);
    assign status.last_byte = out_last;

endmodule

// ===== design/drive_direct_round_robin_framer_unit.sv =====
// channel  dir  tdata (low bit up)                           tuser  tlast
// s_axis   in   robot[3:0] right_speed[19:4] left_speed[35:20] mode   -
// m_axis   out  frame_byte[7:0] target_robot[11:8]            -      last
// cfg      in   cfg_wdata = robot_count, written when cfg_we
//
// A set word is accepted in IDLE and stores its speeds. A tick word is
// accepted in IDLE and starts the speed table read; READ shapes the speeds,
// then SEND gives the seven frame bytes, stalling while m_axis is not ready.
// s_axis_tready is low while a frame is in flight, so no new word is taken.
// Reset clears the speed table (per-entry valid bits), pointer and count=1.
module drive_direct_round_robin_framer_unit #(
    parameter int MAX_ROBOTS = ddrrf_pkg::MAX_ROBOTS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ddrrf_pkg::COUNT_W-1:0]     cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [ddrrf_pkg::IN_DATA_W-1:0]   s_axis_tdata,   // robot, right_speed, left_speed
    input  logic                              s_axis_tuser,   // mode
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [ddrrf_pkg::OUT_DATA_W-1:0]  m_axis_tdata,   // frame_byte, target_robot
    output logic                              m_axis_tlast
);

    ddrrf_pkg::cmd_t    cmd;
    ddrrf_pkg::status_t status;

    ddrrf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_mode   (s_axis_tuser),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .status    (status)
    );

    ddrrf_dp #(
        .MAX_ROBOTS (MAX_ROBOTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_axis_tdata),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
